/* design/bni_pkg.sv */
// Shared types and constants for the batch normalization inference block.
`default_nettype none
package bni_pkg;

   localparam int CHANNELS = 256;
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // restoring divide: 63 quotient bits; bitwise square root: 32 root bits
   localparam int DIV_STEPS = 63;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W = $clog2(DIV_STEPS);

   localparam logic CSR_SCALE_FACTOR = 1'b0;
   localparam logic CSR_EPSILON = 1'b1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef struct packed {
      logic               zero;
      logic        [31:0] inv;
      logic signed [31:0] shift;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQRT,
      ST_WRITE
   } load_state_type;

endpackage
`default_nettype wire

/* design/batch_norm_inference.sv */
// Top level of the batch normalization inference block.
//
//  channel | ports                                   | transaction
//  --------+-----------------------------------------+----------------------------
//  req     | req_valid/req_ready, req_type, fields   | load stats or one sample
//  rsp     | rsp_valid/rsp_ready, normalized, flags  | one result per sample
//  csr     | csr_write, csr_index, csr_wdata         | register write, no wait
//
// Data transactions enter one per cycle while req_ready is high; rsp_valid is
// registered through table read, subtract, 32x32 multiply and round/saturate.
// A load transaction holds req_ready low after its accept for its 63 divide
// steps, 32 root steps and 1 table write; a zero divisor skips straight to the
// write. A following sample on that channel sees the new stats.
// Synchronous active-high reset clears control state only; the stats table is
// undefined until loaded. Per-stage valid bits let bubbles collapse on stalls.
`default_nettype none
module batch_norm_inference (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [7:0]         req_channel,
   input  wire logic signed [15:0] req_sample,
   input  wire logic signed [15:0] req_stat_mean,
   input  wire logic [15:0]        req_stat_variance,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_normalized,
   output logic [7:0]              rsp_out_channel,
   output logic                    rsp_zero_divisor,
   output logic                    rsp_saturated,
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import bni_pkg::*;

   logic [15:0] scale_factor_ff, epsilon_ff;
   logic        busy, stage_ready, accept, in_range;
   logic [ADDR_W-1:0] addr;
   wr_type      wr;
   entry_type   entry;
   logic [$bits(entry_type)-1:0] rd_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= 16'd256;
         epsilon_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCALE_FACTOR: scale_factor_ff <= csr_wdata;
            CSR_EPSILON:      epsilon_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // channels beyond the table are accepted and dropped
   assign in_range = (int'(req_channel) < CHANNELS);
   assign addr = ADDR_W'(req_channel);
   assign req_ready = stage_ready && !busy;
   assign accept = req_valid && req_ready;

   bni_stats u_stats (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && in_range && (req_type == KIND_LOAD)),
      .channel       (addr),
      .stat_mean     (req_stat_mean),
      .stat_variance (req_stat_variance),
      .scale_factor  (scale_factor_ff),
      .epsilon       (epsilon_ff),
      .busy          (busy),
      .wr            (wr)
   );

   bni_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (stage_ready),
      .rd_addr (addr),
      .rd_data (rd_bits)
   );

   assign entry = entry_type'(rd_bits);

   bni_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept && in_range && (req_type == KIND_DATA)),
      .in_channel       (req_channel),
      .in_sample        (req_sample),
      .entry            (entry),
      .stage_ready      (stage_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_normalized   (rsp_normalized),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_zero_divisor (rsp_zero_divisor),
      .rsp_saturated    (rsp_saturated)
   );
endmodule
`default_nettype wire

/* design/bni_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bni_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* design/bni_stats.sv */
// Load unit: scaled mean, divisor, iterative divide and square root per channel.
`default_nettype none
module bni_stats (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [bni_pkg::ADDR_W-1:0] channel,
   input  wire logic signed [15:0]        stat_mean,
   input  wire logic [15:0]               stat_variance,
   input  wire logic [15:0]               scale_factor,
   input  wire logic [15:0]               epsilon,
   output logic                           busy,
   output bni_pkg::wr_type                wr
);
   import bni_pkg::*;

   load_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] addr_ff;
   logic signed [31:0] shift_ff;
   logic [31:0] d_ff;
   logic        zero_ff;
   logic [32:0] rem_ff, rem_in;
   logic [62:0] quo_ff, quo_in;
   logic [63:0] n_ff, n_in, root_ff, root_in, bit_ff;

   logic [31:0] d_in;
   logic signed [32:0] shift_full;
   logic [32:0] r_sh;
   logic        qbit;
   logic [63:0] t;

   // largest value 65535 * 65536 still fits in 32 bits
   assign d_in = {16'd0, stat_variance} * {16'd0, scale_factor} + {16'd0, epsilon};
   assign shift_full = stat_mean * $signed({1'b0, scale_factor});

   // one restoring divide step; only bit 62 of the dividend 2^62 is set
   always_comb begin
      r_sh = {rem_ff[31:0], (cnt_ff == CNT_W'(DIV_STEPS - 1))};
      qbit = (r_sh >= {1'b0, d_ff});
      rem_in = qbit ? (r_sh - {1'b0, d_ff}) : r_sh;
      quo_in = {quo_ff[61:0], qbit};
   end

   // one square root step
   always_comb begin
      t = root_ff + bit_ff;
      if (n_ff >= t) begin
         n_in = n_ff - t;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         n_in = n_ff;
         root_in = root_ff >> 1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (d_in == 32'd0) ? ST_WRITE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
      wr.en = (state_ff == ST_WRITE);
      wr.addr = addr_ff;
      wr.data.zero = zero_ff;
      wr.data.inv = root_ff[31:0];
      wr.data.shift = shift_ff;
   end

   always_comb begin
      cnt_in = cnt_ff - CNT_W'(1);
      if (state_ff == ST_IDLE) begin
         cnt_in = CNT_W'(DIV_STEPS - 1);
      end else if (state_ff == ST_DIV && cnt_ff == '0) begin
         cnt_in = CNT_W'(SQRT_STEPS - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      case (state_ff)
         ST_IDLE: begin
            addr_ff <= channel;
            shift_ff <= shift_full[31:0];
            d_ff <= d_in;
            zero_ff <= (d_in == 32'd0);
            rem_ff <= '0;
            quo_ff <= '0;
            root_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            if (cnt_ff == '0) begin
               n_ff <= {1'b0, quo_in};
               root_ff <= '0;
               bit_ff <= 64'd1 << 62;
            end
         end
         ST_SQRT: begin
            n_ff <= n_in;
            root_ff <= root_in;
            bit_ff <= bit_ff >> 2;
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

/* design/bni_datapath.sv */
// Data pipeline: subtract shift, multiply by inverse std, round and saturate.
`default_nettype none
module bni_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_channel,
   input  wire logic signed [15:0]  in_sample,
   input  wire bni_pkg::entry_type  entry,
   output logic                     stage_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [15:0]       rsp_normalized,
   output logic [7:0]               rsp_out_channel,
   output logic                     rsp_zero_divisor,
   output logic                     rsp_saturated
);
   import bni_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   logic [7:0]         ch1_ff, ch2_ff, ch3_ff;
   logic signed [15:0] x1_ff;
   logic [31:0]        mag2_ff, inv2_ff;
   logic               neg2_ff, zero2_ff, neg3_ff, zero3_ff;
   logic [63:0]        p3_ff;

   logic signed [32:0] xs, sh, diff, mag_full;
   logic [64:0]        pr;
   logic [33:0]        q;
   logic [15:0]        y;
   logic               sat;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign stage_ready = en1;

   always_comb begin
      xs = {{9{x1_ff[15]}}, x1_ff, 8'd0};
      sh = {entry.shift[31], entry.shift};
      diff = xs - sh;
      mag_full = diff[32] ? -diff : diff;
   end

   always_comb begin
      pr = {1'b0, p3_ff} + (65'd1 << 30);
      q = pr[64:31];
      sat = 1'b0;
      if (neg3_ff) begin
         if (q > 34'd32768) begin
            sat = 1'b1;
            y = 16'h8000;
         end else begin
            y = ~q[15:0] + 16'd1;
         end
      end else begin
         if (q > 34'd32767) begin
            sat = 1'b1;
            y = 16'h7FFF;
         end else begin
            y = q[15:0];
         end
      end
      if (zero3_ff) begin
         y = '0;
         sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ch1_ff <= in_channel;
         x1_ff <= in_sample;
      end
      if (en2) begin
         ch2_ff <= ch1_ff;
         mag2_ff <= mag_full[31:0];
         neg2_ff <= diff[32];
         inv2_ff <= entry.inv;
         zero2_ff <= entry.zero;
      end
      if (en3) begin
         ch3_ff <= ch2_ff;
         p3_ff <= mag2_ff * inv2_ff;
         neg3_ff <= neg2_ff;
         zero3_ff <= zero2_ff;
      end
      if (en4) begin
         rsp_out_channel <= ch3_ff;
         rsp_normalized <= y;
         rsp_zero_divisor <= zero3_ff;
         rsp_saturated <= sat;
      end
   end

   assign rsp_valid = v4_ff;
endmodule
`default_nettype wire
